// ===== sv/assert_macros.svh =====
// Assertion helpers for the RTL files; ffws_ctrl includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is high.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Clocked check that also holds across reset.
`define ASSERT_RST(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/ffws_pkg.sv =====
// ----------------------------------------------------------------------------
// ffws_pkg
// Types, widths, constants and tables of the formation follower wheel-speed
// block.
// ----------------------------------------------------------------------------
`default_nettype none

package ffws_pkg;

  localparam int NUM_SENSORS  = 8;
  localparam int CORDIC_STEPS = 14;
  localparam int ATAN_ENTRIES = 20;
  localparam int CORDIC_RUN   = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
  localparam int STEP_W       = $clog2(ATAN_ENTRIES);

  localparam int IR_PORTS  = 8;
  localparam int IR_W      = 12;
  localparam int RANGE_W   = 16;
  localparam int ANGIN_W   = 15;
  localparam int HELD_W    = 16;
  localparam int GAIN_W    = 12;
  localparam int SPEED_W   = 16;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DAT_W = 16;

  localparam int ANG_W  = 18;  // angle before wrapping
  localparam int Z_W    = 28;  // CORDIC angle accumulator, Q24
  localparam int XY_W   = 27;  // CORDIC vector, Q24
  localparam int Q_W    = 30;  // goal point x/y, Q24
  localparam int MA_W   = 35;  // multiplier operand a, also u and w
  localparam int MB_W   = 27;  // multiplier operand b
  localparam int PROD_W = MA_W + MB_W;
  localparam int SUM_W  = PROD_W + 1;
  localparam int Q40_W  = SUM_W - 40;
  localparam int SP_W   = Q40_W + 1;
  localparam int BR_W   = 20;  // Braitenberg sum
  localparam int BQ_W   = 12;  // Braitenberg quotient
  localparam int DIV_SHIFT = 28;
  localparam int DIV_M_W   = 20;
  localparam int DIV_M     = 671089;  // ceil(2^28 / 400)

  localparam int PI_Q12      = 12868;
  localparam int HALF_PI_Q12 = 6434;
  localparam int TWO_PI_Q12  = 25736;
  localparam int CORDIC_K    = 10188014;
  localparam int SPEED_A     = 50905701;
  localparam int SPEED_B     = 1323548;

  localparam int RANGE_RST = 1638;
  localparam int FGAIN_RST = 512;
  localparam int TGAIN_RST = 2560;
  localparam int HGAIN_RST = 256;

  localparam logic [CFG_IDX_W-1:0] REG_GOAL_RANGE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GOAL_BEARING = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FWD_GAIN     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TURN_GAIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HEAD_GAIN    = 3'd4;

  typedef logic [IR_PORTS-1:0][IR_W-1:0] ir_array_t;

  typedef enum logic [3:0] {
    OP_XC1, OP_XC2, OP_YS1, OP_YS2, OP_UF, OP_WT, OP_WH, OP_AU, OP_BW
  } op_t;

  typedef struct packed {
    logic              load;
    logic              div;
    logic              cinit;
    logic              cstep;
    logic              cstore;
    logic              csel;
    logic [STEP_W-1:0] step;
    logic              mul;
    logic              acc;
    op_t               op;
    logic              fin;
    logic              out_load;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

  function automatic logic signed [5:0] weight(input logic [3:0] idx);
    logic signed [5:0] w;
    case (idx)
      4'd0:  w = -6'sd5;
      4'd1:  w = -6'sd15;
      4'd2:  w = -6'sd20;
      4'd3:  w = 6'sd6;
      4'd4:  w = 6'sd4;
      4'd5:  w = 6'sd6;
      4'd6:  w = 6'sd3;
      4'd7:  w = 6'sd5;
      4'd8:  w = 6'sd4;
      4'd9:  w = 6'sd4;
      4'd10: w = 6'sd6;
      4'd11: w = -6'sd18;
      4'd12: w = -6'sd15;
      4'd13: w = -6'sd5;
      4'd14: w = 6'sd5;
      4'd15: w = 6'sd3;
      default: w = 6'sd0;
    endcase
    return w;
  endfunction

  function automatic logic [23:0] atan_q24(input logic [STEP_W-1:0] k);
    logic [23:0] a;
    case (k)
      5'd0:  a = 24'd13176795;
      5'd1:  a = 24'd7778716;
      5'd2:  a = 24'd4110060;
      5'd3:  a = 24'd2086331;
      5'd4:  a = 24'd1047214;
      5'd5:  a = 24'd524117;
      5'd6:  a = 24'd262123;
      5'd7:  a = 24'd131069;
      5'd8:  a = 24'd65536;
      5'd9:  a = 24'd32768;
      5'd10: a = 24'd16384;
      5'd11: a = 24'd8192;
      5'd12: a = 24'd4096;
      5'd13: a = 24'd2048;
      5'd14: a = 24'd1024;
      5'd15: a = 24'd512;
      5'd16: a = 24'd256;
      5'd17: a = 24'd128;
      5'd18: a = 24'd64;
      5'd19: a = 24'd32;
      default: a = 24'd0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

// ===== sv/ffws_ctrl.sv =====
// ----------------------------------------------------------------------------
// ffws_ctrl
// Sequencer: input transfer, divide, CORDIC passes, multiply schedule, output load.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ffws_ctrl (
  input  wire                clk,
  input  wire                rst,
  input  wire                in_valid,
  output logic               in_ready,
  input  ffws_pkg::status_t  status,
  output ffws_pkg::cmd_t     cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_CINIT, S_CRUN, S_CSTORE, S_MUL, S_ACC, S_FIN, S_OUT
  } state_t;

  state_t                      state;
  logic                        sel;
  logic [ffws_pkg::STEP_W-1:0] step;
  ffws_pkg::op_t               op;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd          = '0;
    cmd.csel     = sel;
    cmd.step     = step;
    cmd.op       = op;
    cmd.load     = (state == S_IDLE) && in_valid;
    cmd.div      = (state == S_DIV);
    cmd.cinit    = (state == S_CINIT);
    cmd.cstep    = (state == S_CRUN);
    cmd.cstore   = (state == S_CSTORE);
    cmd.mul      = (state == S_MUL);
    cmd.acc      = (state == S_ACC);
    cmd.fin      = (state == S_FIN);
    cmd.out_load = (state == S_OUT) && status.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sel   <= 1'b0;
      step  <= '0;
      op    <= ffws_pkg::OP_XC1;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) state <= S_DIV;
        end
        S_DIV: begin
          sel   <= 1'b0;
          state <= S_CINIT;
        end
        S_CINIT: begin
          step  <= '0;
          state <= S_CRUN;
        end
        S_CRUN: begin
          if (step == ffws_pkg::STEP_W'(ffws_pkg::CORDIC_RUN - 1)) begin
            state <= S_CSTORE;
          end else begin
            step <= step + 1'b1;
          end
        end
        S_CSTORE: begin
          if (!sel) begin
            sel   <= 1'b1;
            state <= S_CINIT;
          end else begin
            op    <= ffws_pkg::OP_XC1;
            state <= S_MUL;
          end
        end
        S_MUL: begin
          state <= S_ACC;
        end
        S_ACC: begin
          if (op == ffws_pkg::OP_BW) begin
            state <= S_FIN;
          end else begin
            op    <= ffws_pkg::op_t'(4'(op) + 4'd1);
            state <= S_MUL;
          end
        end
        S_FIN: begin
          state <= S_OUT;
        end
        S_OUT: begin
          if (status.out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_CLK(a_one_cmd, $onehot0({cmd.load, cmd.div, cmd.cinit, cmd.cstep, cmd.cstore, cmd.mul, cmd.acc, cmd.fin, cmd.out_load}), "more than one datapath command")
  `ASSERT_CLK(a_load_div, cmd.load |=> cmd.div, "transfer not followed by divide")
  `ASSERT_CLK(a_mul_acc, cmd.mul |=> (cmd.acc && $stable(op)), "product not accumulated")
  `ASSERT_RST(a_rst_ready, rst |=> in_ready, "not ready after reset")

endmodule

`default_nettype wire

// ===== sv/ffws_dp.sv =====
// ----------------------------------------------------------------------------
// ffws_dp
// Datapath: config and leader registers, CORDIC unit, shared multiplier,
// Braitenberg sum, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ffws_dp (
  input  wire                                    clk,
  input  wire                                    rst,
  input  ffws_pkg::cmd_t                         cmd,
  output ffws_pkg::status_t                      status,
  input  ffws_pkg::ir_array_t                    ir,
  input  wire                                    meas_valid,
  input  wire        [ffws_pkg::RANGE_W-1:0]     meas_range,
  input  wire signed [ffws_pkg::ANGIN_W-1:0]     meas_bearing,
  input  wire signed [ffws_pkg::ANGIN_W-1:0]     meas_heading,
  input  wire                                    cfg_valid,
  output logic                                   cfg_ready,
  input  wire        [ffws_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire        [ffws_pkg::CFG_DAT_W-1:0]   cfg_data,
  output logic                                   out_valid,
  input  wire                                    out_ready,
  output logic signed [ffws_pkg::SPEED_W-1:0]    left_speed,
  output logic signed [ffws_pkg::SPEED_W-1:0]    right_speed
);

  localparam int ANG_W  = ffws_pkg::ANG_W;
  localparam int Z_W    = ffws_pkg::Z_W;
  localparam int XY_W   = ffws_pkg::XY_W;
  localparam int Q_W    = ffws_pkg::Q_W;
  localparam int MA_W   = ffws_pkg::MA_W;
  localparam int MB_W   = ffws_pkg::MB_W;
  localparam int PROD_W = ffws_pkg::PROD_W;
  localparam int SUM_W  = ffws_pkg::SUM_W;
  localparam int Q40_W  = ffws_pkg::Q40_W;
  localparam int SP_W   = ffws_pkg::SP_W;
  localparam int BR_W   = ffws_pkg::BR_W;
  localparam int BQ_W   = ffws_pkg::BQ_W;
  localparam int HELD_W = ffws_pkg::HELD_W;
  localparam int GAIN_W = ffws_pkg::GAIN_W;
  localparam int RANGE_W = ffws_pkg::RANGE_W;
  localparam int ANGIN_W = ffws_pkg::ANGIN_W;
  localparam int DIV_W  = BR_W + ffws_pkg::DIV_M_W;
  localparam int IR_W_SEL = ffws_pkg::IR_W + 7;
  localparam int SPEED_OUT_W = ffws_pkg::SPEED_W;

  localparam logic signed [ANG_W-1:0] PI_A      = ANG_W'(ffws_pkg::PI_Q12);
  localparam logic signed [ANG_W-1:0] NEG_PI_A  = -ANG_W'(ffws_pkg::PI_Q12);
  localparam logic signed [ANG_W-1:0] TWO_PI_A  = ANG_W'(ffws_pkg::TWO_PI_Q12);
  localparam logic signed [ANG_W-1:0] HALF_A    = ANG_W'(ffws_pkg::HALF_PI_Q12);
  localparam logic signed [ANG_W-1:0] NEG_HALF_A = -ANG_W'(ffws_pkg::HALF_PI_Q12);
  localparam logic signed [XY_W-1:0]  K_XY      = XY_W'(ffws_pkg::CORDIC_K);
  localparam logic signed [MB_W-1:0]  A_MB      = MB_W'(ffws_pkg::SPEED_A);
  localparam logic signed [MB_W-1:0]  B_MB      = MB_W'(ffws_pkg::SPEED_B);
  localparam logic [ffws_pkg::DIV_M_W-1:0] DIV_M_C = ffws_pkg::DIV_M_W'(ffws_pkg::DIV_M);
  localparam logic signed [SUM_W-1:0] RND40     = SUM_W'((64'd1 << 40) - 64'd1);
  localparam logic signed [SP_W-1:0]  SAT_HI    = SP_W'(32767);
  localparam logic signed [SP_W-1:0]  SAT_LO    = -SP_W'(32768);

  // configuration
  logic        [RANGE_W-1:0]   offs_range;
  logic signed [ANGIN_W-1:0]   offs_bearing;
  logic        [GAIN_W-1:0]    fwd_gain;
  logic        [GAIN_W-1:0]    turn_gain;
  logic        [GAIN_W-1:0]    head_gain;

  // leader state
  logic        [RANGE_W-1:0]   held_range;
  logic signed [HELD_W-1:0]    held_bearing;
  logic signed [HELD_W-1:0]    held_heading;

  // Braitenberg
  logic signed [BR_W-1:0]      bsum_l, bsum_r;
  logic signed [BQ_W-1:0]      bq_l, bq_r;

  // CORDIC
  logic signed [XY_W-1:0]      cx, cy;
  logic signed [Z_W-1:0]       cz;
  logic                        cneg;
  logic signed [XY_W-1:0]      c1, s1, c2, s2;

  // multiply chain
  logic signed [PROD_W-1:0]    prod;
  logic signed [Q_W-1:0]       xq, yq;
  logic signed [MA_W-1:0]      u, w;
  logic signed [PROD_W-1:0]    au, bw;
  logic signed [SUM_W-1:0]     lsum, rsum;

  assign cfg_ready       = 1'b1;
  assign status.out_free = !out_valid || out_ready;

  // ---- configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      offs_range   <= RANGE_W'(ffws_pkg::RANGE_RST);
      offs_bearing <= '0;
      fwd_gain     <= GAIN_W'(ffws_pkg::FGAIN_RST);
      turn_gain    <= GAIN_W'(ffws_pkg::TGAIN_RST);
      head_gain    <= GAIN_W'(ffws_pkg::HGAIN_RST);
    end else if (cfg_valid) begin
      case (cfg_index)
        ffws_pkg::REG_GOAL_RANGE:   offs_range   <= cfg_data[RANGE_W-1:0];
        ffws_pkg::REG_GOAL_BEARING: offs_bearing <= $signed(cfg_data[ANGIN_W-1:0]);
        ffws_pkg::REG_FWD_GAIN:     fwd_gain     <= cfg_data[GAIN_W-1:0];
        ffws_pkg::REG_TURN_GAIN:    turn_gain    <= cfg_data[GAIN_W-1:0];
        ffws_pkg::REG_HEAD_GAIN:    head_gain    <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- Braitenberg weighted sums of the sensor ports
  logic signed [BR_W-1:0] bsum_l_next, bsum_r_next;
  always_comb begin
    logic signed [IR_W_SEL-1:0] pr, pl;
    bsum_l_next = '0;
    bsum_r_next = '0;
    for (int i = 0; i < ffws_pkg::NUM_SENSORS; i++) begin
      pr = $signed({1'b0, ir[i]}) * ffws_pkg::weight(4'(i));
      pl = $signed({1'b0, ir[i]}) * ffws_pkg::weight(4'(i + ffws_pkg::NUM_SENSORS));
      bsum_r_next = bsum_r_next + BR_W'(pr);
      bsum_l_next = bsum_l_next + BR_W'(pl);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_range   <= '0;
      held_bearing <= '0;
      held_heading <= '0;
    end else if (cmd.load && meas_valid) begin
      held_range   <= meas_range;
      held_bearing <= HELD_W'(meas_bearing);
      held_heading <= HELD_W'(meas_heading);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      bsum_l <= bsum_l_next;
      bsum_r <= bsum_r_next;
    end
  end

  // ---- divide by 400: magnitude times reciprocal, exact over the sum range
  function automatic logic signed [BQ_W-1:0] div400(input logic signed [BR_W-1:0] s);
    logic [BR_W-1:0]  mag;
    logic [DIV_W-1:0] p;
    logic [BQ_W-1:0]  q;
    mag = s[BR_W-1] ? BR_W'(-s) : BR_W'(s);
    p   = DIV_W'(mag) * DIV_W'(DIV_M_C);
    q   = BQ_W'(p >> ffws_pkg::DIV_SHIFT);
    return s[BR_W-1] ? $signed(-q) : $signed(q);
  endfunction

  always_ff @(posedge clk) begin
    if (cmd.div) begin
      bq_l <= div400(bsum_l);
      bq_r <= div400(bsum_r);
    end
  end

  // ---- CORDIC angle preparation: wrap into [-pi, pi], fold into [-pi/2, pi/2]
  logic signed [ANG_W-1:0] ang, aw;
  logic signed [Z_W-1:0]   zt, z0;
  logic                    neg0;
  always_comb begin
    if (cmd.csel) begin
      ang = ANG_W'(held_heading) + ANG_W'(offs_bearing) - PI_A;
    end else begin
      ang = ANG_W'(held_bearing);
    end
    aw = ang;
    for (int k = 0; k < 2; k++) begin
      if (aw > PI_A) aw = aw - TWO_PI_A;
      if (aw < NEG_PI_A) aw = aw + TWO_PI_A;
    end
    neg0 = 1'b0;
    if (aw > HALF_A) begin
      aw   = aw - PI_A;
      neg0 = 1'b1;
    end else if (aw < NEG_HALF_A) begin
      aw   = aw + PI_A;
      neg0 = 1'b1;
    end
    zt = Z_W'(aw);
    z0 = zt <<< 12;
  end

  logic signed [XY_W-1:0] dx, dy;
  logic signed [Z_W-1:0]  at;
  assign dx = cy >>> cmd.step;
  assign dy = cx >>> cmd.step;
  assign at = $signed(Z_W'(ffws_pkg::atan_q24(cmd.step)));

  always_ff @(posedge clk) begin
    if (cmd.cinit) begin
      cx   <= K_XY;
      cy   <= '0;
      cz   <= z0;
      cneg <= neg0;
    end else if (cmd.cstep) begin
      if (!cz[Z_W-1]) begin
        cx <= cx - dx;
        cy <= cy + dy;
        cz <= cz - at;
      end else begin
        cx <= cx + dx;
        cy <= cy - dy;
        cz <= cz + at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.cstore) begin
      if (cmd.csel) begin
        c2 <= cneg ? -cx : cx;
        s2 <= cneg ? -cy : cy;
      end else begin
        c1 <= cneg ? -cx : cx;
        s1 <= cneg ? -cy : cy;
      end
    end
  end

  // ---- shared multiplier
  logic signed [MA_W-1:0] ma;
  logic signed [MB_W-1:0] mb;
  always_comb begin
    case (cmd.op)
      ffws_pkg::OP_XC1: begin ma = MA_W'(c1); mb = $signed(MB_W'(held_range)); end
      ffws_pkg::OP_XC2: begin ma = MA_W'(c2); mb = $signed(MB_W'(offs_range)); end
      ffws_pkg::OP_YS1: begin ma = MA_W'(s1); mb = $signed(MB_W'(held_range)); end
      ffws_pkg::OP_YS2: begin ma = MA_W'(s2); mb = $signed(MB_W'(offs_range)); end
      ffws_pkg::OP_UF:  begin ma = MA_W'(xq); mb = $signed(MB_W'(fwd_gain));   end
      ffws_pkg::OP_WT:  begin ma = MA_W'(yq); mb = $signed(MB_W'(turn_gain));  end
      ffws_pkg::OP_WH:  begin ma = MA_W'(held_heading); mb = $signed(MB_W'(head_gain)); end
      ffws_pkg::OP_AU:  begin ma = u; mb = A_MB; end
      ffws_pkg::OP_BW:  begin ma = w; mb = B_MB; end
      default:          begin ma = '0; mb = '0; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul) prod <= ma * mb;
  end

  logic signed [PROD_W-1:0] p14, p8, p16x;
  assign p14  = prod >>> 14;
  assign p8   = prod >>> 8;
  assign p16x = prod <<< 4;

  always_ff @(posedge clk) begin
    if (cmd.acc) begin
      case (cmd.op)
        ffws_pkg::OP_XC1: xq <= p14[Q_W-1:0];
        ffws_pkg::OP_XC2: xq <= xq + p14[Q_W-1:0];
        ffws_pkg::OP_YS1: yq <= p14[Q_W-1:0];
        ffws_pkg::OP_YS2: yq <= yq + p14[Q_W-1:0];
        ffws_pkg::OP_UF:  u  <= p8[MA_W-1:0];
        ffws_pkg::OP_WT:  w  <= p8[MA_W-1:0];
        ffws_pkg::OP_WH:  w  <= w + p16x[MA_W-1:0];
        ffws_pkg::OP_AU:  au <= prod;
        ffws_pkg::OP_BW:  bw <= prod;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      lsum <= SUM_W'(au) - SUM_W'(bw);
      rsum <= SUM_W'(au) + SUM_W'(bw);
    end
  end

  // ---- divide by 2^40 toward zero, add Braitenberg term, clamp
  function automatic logic signed [SPEED_OUT_W-1:0] wheel(input logic signed [SUM_W-1:0] s,
                                                          input logic signed [BQ_W-1:0] b);
    logic signed [SUM_W-1:0] t;
    logic signed [SUM_W-1:0] sh;
    logic signed [SP_W-1:0]  v;
    t  = s[SUM_W-1] ? s + RND40 : s;
    sh = t >>> 40;
    v  = SP_W'($signed(sh[Q40_W-1:0])) + SP_W'(b);
    if (v > SAT_HI) v = SAT_HI;
    else if (v < SAT_LO) v = SAT_LO;
    return v[SPEED_OUT_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      left_speed  <= wheel(lsum, bq_l);
      right_speed <= wheel(rsum, bq_r);
    end
  end

endmodule

`default_nettype wire

// ===== sv/formation_follow_wheel_speed.sv =====
// ----------------------------------------------------------------------------
// formation_follow_wheel_speed
// Leader-follower wheel-speed controller: goal point from held leader state,
// forward and turn commands, wheel speeds plus Braitenberg avoidance.
// ----------------------------------------------------------------------------
//
//   channel  direction  handshake              payload
//   in       sink       in_valid / in_ready    ir_0..ir_7, meas_*
//   out      source     out_valid / out_ready  left_speed, right_speed
//   cfg      sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// An item runs from one input transfer to the earliest next one through the
// iterative CORDIC unit (two passes, one step a cycle) and the shared
// multiplier (nine products, each multiplied and then accumulated); no new
// input transfers before the item is loaded into the output register.
// Reset is synchronous: config returns to defaults, leader state to zero.
// A new input transfers while a finished result still waits on out; the
// sequencer holds in its last state only if that earlier result is untaken.
// cfg_ready is always high; write registers only while the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module formation_follow_wheel_speed (
  input  wire                                   clk,
  input  wire                                   rst,
  input  wire                                   in_valid,
  output logic                                  in_ready,
  input  wire        [ffws_pkg::IR_W-1:0]       ir_0,
  input  wire        [ffws_pkg::IR_W-1:0]       ir_1,
  input  wire        [ffws_pkg::IR_W-1:0]       ir_2,
  input  wire        [ffws_pkg::IR_W-1:0]       ir_3,
  input  wire        [ffws_pkg::IR_W-1:0]       ir_4,
  input  wire        [ffws_pkg::IR_W-1:0]       ir_5,
  input  wire        [ffws_pkg::IR_W-1:0]       ir_6,
  input  wire        [ffws_pkg::IR_W-1:0]       ir_7,
  input  wire                                   meas_valid,
  input  wire        [ffws_pkg::RANGE_W-1:0]    meas_range,
  input  wire signed [ffws_pkg::ANGIN_W-1:0]    meas_bearing,
  input  wire signed [ffws_pkg::ANGIN_W-1:0]    meas_heading,
  output logic                                  out_valid,
  input  wire                                   out_ready,
  output logic signed [ffws_pkg::SPEED_W-1:0]   left_speed,
  output logic signed [ffws_pkg::SPEED_W-1:0]   right_speed,
  input  wire                                   cfg_valid,
  output logic                                  cfg_ready,
  input  wire        [ffws_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire        [ffws_pkg::CFG_DAT_W-1:0]  cfg_data
);

  ffws_pkg::cmd_t      cmd;
  ffws_pkg::status_t   status;
  ffws_pkg::ir_array_t ir;

  // gather the sensor ports into one vector, sensor 0 at index 0
  assign ir = {ir_7, ir_6, ir_5, ir_4, ir_3, ir_2, ir_1, ir_0};

  // sequencer: steps through capture, divide, two CORDIC passes, products, output load
  ffws_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: holds config, leader state, Braitenberg sums, CORDIC, multiplier, output register
  ffws_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .ir           (ir),
    .meas_valid   (meas_valid),
    .meas_range   (meas_range),
    .meas_bearing (meas_bearing),
    .meas_heading (meas_heading),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .left_speed   (left_speed),
    .right_speed  (right_speed)
  );

endmodule

`default_nettype wire
